### hw/rtl/tpt_pkg.sv
// Package for the timestamped price table: request and status codes, queue entry type.
// No dependencies.
package tpt_pkg;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned PriceW = 32;

    typedef enum logic [1:0] {
        REQ_UPDATE  = 2'd0,
        REQ_CORRECT = 2'd1,
        REQ_REMOVE  = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_DUP     = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        t_req              req;
        logic [TimeW-1:0]  key;
        logic [PriceW-1:0] price;
    } t_cmd;

    typedef struct packed {
        t_status           status;
        logic              is_empty;
        logic [PriceW-1:0] low_price;
        logic [PriceW-1:0] high_price;
        logic [PriceW-1:0] last_price;
    } t_res;
endpackage

### hw/rtl/tpt_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on tpt_pkg.
interface tpt_req_if;
    import tpt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           req_type;
    logic signed [31:0]   event_time;
    logic [31:0]          price_value;
    modport source (output valid, req_type, event_time, price_value, input ready);
    modport sink   (input valid, req_type, event_time, price_value, output ready);
endinterface

interface tpt_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        is_empty;
    logic [31:0] low_price;
    logic [31:0] high_price;
    logic [31:0] last_price;
    modport source (output valid, status, is_empty, low_price, high_price, last_price,
                    input ready);
    modport sink   (input valid, status, is_empty, low_price, high_price, last_price,
                    output ready);
endinterface

### hw/rtl/tpt_front.sv
// Front end: accepts request beats, decodes the type and pushes commands into a
// two-entry queue. Depends on tpt_pkg.
module tpt_front import tpt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tpt_req_if.sink s_req,
    output t_cmd   o_cmd,
    output logic   o_cmd_valid,
    input  logic   i_cmd_pop
);
    t_cmd       r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd, r_wr;
    logic       push;
    t_cmd       cmd_in;

    assign s_req.ready = (r_cnt != 2'd2);
    assign push        = s_req.valid && s_req.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        cmd_in.key   = s_req.event_time;
        cmd_in.price = s_req.price_value;
        cmd_in.req   = t_req'(s_req.req_type);
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= cmd_in;
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (i_cmd_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_cmd_pop};
        end
    end
endmodule

### hw/rtl/tpt_back.sv
// Back end: slot table with parallel key match, a registered update, then a
// registered min/max/latest reduction tree; output register. Depends on tpt_pkg.
module tpt_back import tpt_pkg::*; #(
    parameter int unsigned Depth = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    input  logic   i_cmd_valid,
    output logic   o_cmd_pop,
    tpt_res_if.source m_res
);
    localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned Lvls = IdxW;
    localparam int unsigned Pad  = 1 << Lvls;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RED  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    typedef struct packed {
        logic              v;
        logic [PriceW-1:0] lo;
        logic [PriceW-1:0] hi;
        logic [TimeW-1:0]  k;
        logic [PriceW-1:0] lp;
    } t_node;

    t_state            r_state;
    logic [Depth-1:0]  r_valid;
    logic [TimeW-1:0]  r_time  [Depth];
    logic [PriceW-1:0] r_price [Depth];
    t_status           r_st;
    t_status           n_st;
    logic [$clog2(Lvls+1)-1:0] r_lvl;
    t_node             r_tree [Pad];
    t_res              r_res;
    logic              r_out_v;

    logic [Depth-1:0]  hit_vec;
    logic              hit;
    logic [IdxW-1:0]   hit_idx, free_idx;
    logic              free_ok;
    logic              start;

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        hit      = 1'b0;
        free_ok  = 1'b0;
        for (int i = Depth - 1; i >= 0; i--) begin
            hit_vec[i] = r_valid[i] && (r_time[i] == i_cmd.key);
            if (hit_vec[i]) begin
                hit     = 1'b1;
                hit_idx = IdxW'(i);
            end
            if (!r_valid[i]) begin
                free_ok  = 1'b1;
                free_idx = IdxW'(i);
            end
        end
    end

    always_comb begin
        n_st = ST_DONE;
        case (i_cmd.req)
            REQ_UPDATE, REQ_CORRECT: begin
                if (hit) begin
                    if (i_cmd.req == REQ_UPDATE) n_st = ST_DUP;
                end else if (!free_ok) n_st = ST_FULL;
            end
            REQ_REMOVE: begin
                if (!hit) n_st = ST_MISSING;
            end
            default: ;
        endcase
    end

    assign start     = (r_state == S_IDLE) && i_cmd_valid && !r_out_v;
    assign o_cmd_pop = start;

    function automatic t_node merge(t_node a, t_node b);
        t_node m;
        if (!a.v) m = b;
        else if (!b.v) m = a;
        else begin
            m.v  = 1'b1;
            m.lo = (b.lo < a.lo) ? b.lo : a.lo;
            m.hi = (b.hi > a.hi) ? b.hi : a.hi;
            if ((b.k ^ 32'h8000_0000) > (a.k ^ 32'h8000_0000)) begin
                m.k  = b.k;
                m.lp = b.lp;
            end else begin
                m.k  = a.k;
                m.lp = a.lp;
            end
        end
        return m;
    endfunction

    assign m_res.valid      = r_out_v;
    assign m_res.status     = r_res.status;
    assign m_res.is_empty   = r_res.is_empty;
    assign m_res.low_price  = r_res.low_price;
    assign m_res.high_price = r_res.high_price;
    assign m_res.last_price = r_res.last_price;

    always_ff @(posedge i_clk) begin
        if (start) begin
            case (i_cmd.req)
                REQ_UPDATE, REQ_CORRECT: begin
                    if (hit && i_cmd.req == REQ_CORRECT) r_price[hit_idx] <= i_cmd.price;
                    else if (!hit && free_ok) begin
                        r_time[free_idx]  <= i_cmd.key;
                        r_price[free_idx] <= i_cmd.price;
                    end
                end
                default: ;
            endcase
        end
        if (r_state == S_RED) begin
            if (r_lvl == '0) begin
                for (int i = 0; i < Pad; i++) begin
                    if (i < Depth) begin
                        r_tree[i].v  <= r_valid[i % Depth];
                        r_tree[i].lo <= r_price[i % Depth];
                        r_tree[i].hi <= r_price[i % Depth];
                        r_tree[i].k  <= r_time[i % Depth];
                        r_tree[i].lp <= r_price[i % Depth];
                    end else r_tree[i] <= '0;
                end
            end else begin
                for (int i = 0; i < Pad / 2; i++)
                    r_tree[i] <= merge(r_tree[2 * i], r_tree[2 * i + 1]);
            end
        end
        if (r_state == S_OUT) begin
            r_res.status     <= r_st;
            r_res.is_empty   <= !r_tree[0].v;
            r_res.low_price  <= r_tree[0].v ? r_tree[0].lo : '0;
            r_res.high_price <= r_tree[0].v ? r_tree[0].hi : '0;
            r_res.last_price <= r_tree[0].v ? r_tree[0].lp : '0;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_out_v <= 1'b0;
            r_lvl   <= '0;
            r_st    <= ST_DONE;
        end else begin
            if (r_out_v && m_res.ready) r_out_v <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_st    <= n_st;
                        r_lvl   <= '0;
                        r_state <= S_RED;
                        case (i_cmd.req)
                            REQ_UPDATE, REQ_CORRECT: begin
                                if (!hit && free_ok) r_valid[free_idx] <= 1'b1;
                            end
                            REQ_REMOVE: begin
                                if (hit) r_valid[hit_idx] <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RED: begin
                    r_lvl <= r_lvl + 1'b1;
                    if (r_lvl == Lvls[$bits(r_lvl)-1:0]) r_state <= S_OUT;
                end
                S_OUT: begin
                    r_out_v <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### hw/rtl/timestamped_price_table_min_max_last.sv
// Timestamped price table, top level. From accept to result: a registered update, a
// registered reduction tree of one level a cycle, one output register; one request
// at a time in the back end, queued two deep in front. A request starts only once
// the previous result beat has left, so no new request enters the back end before
// the last one is through.
// Synchronous active-low reset empties the table at once.
module timestamped_price_table_min_max_last import tpt_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tpt_req_if.sink   s_req,
    tpt_res_if.source m_res
);
    t_cmd cmd;
    logic cmd_valid, cmd_pop;

    tpt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_req(s_req),
        .o_cmd(cmd), .o_cmd_valid(cmd_valid), .i_cmd_pop(cmd_pop)
    );

    tpt_back #(.Depth(TABLE_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_cmd_valid(cmd_valid),
        .o_cmd_pop(cmd_pop), .m_res(m_res)
    );
endmodule

### dv/tb_timestamped_price_table_min_max_last.sv
// Testbench for the timestamped price table: drives request beats, predicts each result
// with its own table model and compares every result beat field by field.
// Depends on tpt_pkg, tpt_if and timestamped_price_table_min_max_last.
module tb_timestamped_price_table_min_max_last;
    import tpt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned Depth = 64;
    localparam int unsigned NRows = 14;

    typedef struct {
        t_req        req;
        logic [31:0] key;
        logic [31:0] price;
        logic        chk;
        t_status     status;
        logic        is_empty;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] last;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    tpt_req_if req_ch();
    tpt_res_if res_ch();

    timestamped_price_table_min_max_last #(.TABLE_DEPTH(Depth)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_req   (req_ch.sink),
        .m_res   (res_ch.source)
    );

    logic        tbl_used [Depth];
    logic [31:0] tbl_time [Depth];
    logic [31:0] tbl_price[Depth];
    t_res        pending_results[$];
    int          n_errors;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;
    logic [31:0] key_pool[16];
    t_row        dir_rows[NRows];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic t_res apply_request(t_req req, logic [31:0] key, logic [31:0] price);
        t_res r;
        int hit;
        int free_slot;
        logic any;
        logic [31:0] last_key;
        hit = -1;
        free_slot = -1;
        any = 1'b0;
        last_key = '0;
        r = '0;
        r.status = ST_DONE;
        for (int i = 0; i < Depth; i++) begin
            if (tbl_used[i] && tbl_time[i] == key && hit < 0) hit = i;
            if (!tbl_used[i] && free_slot < 0) free_slot = i;
        end
        if (req == REQ_REMOVE) begin
            if (hit >= 0) tbl_used[hit] = 1'b0;
            else r.status = ST_MISSING;
        end else if (req != REQ_NONE) begin
            if (hit >= 0) begin
                if (req == REQ_UPDATE) r.status = ST_DUP;
                else tbl_price[hit] = price;
            end else if (free_slot < 0) begin
                r.status = ST_FULL;
            end else begin
                tbl_used[free_slot]  = 1'b1;
                tbl_time[free_slot]  = key;
                tbl_price[free_slot] = price;
            end
        end
        for (int i = 0; i < Depth; i++) begin
            if (tbl_used[i]) begin
                if (!any || tbl_price[i] < r.low_price) r.low_price = tbl_price[i];
                if (!any || tbl_price[i] > r.high_price) r.high_price = tbl_price[i];
                if (!any || $signed(tbl_time[i]) > $signed(last_key)) begin
                    last_key = tbl_time[i];
                    r.last_price = tbl_price[i];
                end
                any = 1'b1;
            end
        end
        r.is_empty = !any;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    task automatic send_beat(t_req req, logic [31:0] key, logic [31:0] price);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= req;
        req_ch.event_time  <= key;
        req_ch.price_value <= price;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_results.insert(pending_results.size(), apply_request(req, key, price));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // result side: random back-pressure, plus a long hold when hold_cycles is set
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", 32'h0, 32'h0);
            end else begin
                want = pending_results.pop_front();
                if (res_ch.status != want.status)
                    report_mismatch("status", 32'(res_ch.status), 32'(want.status));
                if (res_ch.is_empty != want.is_empty)
                    report_mismatch("is_empty", 32'(res_ch.is_empty), 32'(want.is_empty));
                if (res_ch.low_price != want.low_price)
                    report_mismatch("low_price", res_ch.low_price, want.low_price);
                if (res_ch.high_price != want.high_price)
                    report_mismatch("high_price", res_ch.high_price, want.high_price);
                if (res_ch.last_price != want.last_price)
                    report_mismatch("last_price", res_ch.last_price, want.last_price);
            end
        end
    end

    function automatic t_row row(t_req req, logic [31:0] key, logic [31:0] price, logic chk,
                                 t_status st, logic emp, logic [31:0] lo, logic [31:0] hi,
                                 logic [31:0] last);
        t_row r;
        r.req = req; r.key = key; r.price = price; r.chk = chk; r.status = st;
        r.is_empty = emp; r.lo = lo; r.hi = hi; r.last = last;
        return r;
    endfunction

    task automatic random_phase(int n_items);
        t_req req;
        logic [31:0] key;
        int pick;
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(99);
            if (pick < 40) req = REQ_UPDATE;
            else if (pick < 65) req = REQ_CORRECT;
            else if (pick < 95) req = REQ_REMOVE;
            else req = REQ_NONE;
            key = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(15)];
            send_beat(req, key, ($urandom_range(3) == 0) ? $urandom() : $urandom_range(2000));
        end
    endtask

    initial begin
        t_res got;
        int k;
        n_errors = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_NONE;
        req_ch.event_time = '0;
        req_ch.price_value = '0;
        for (int i = 0; i < Depth; i++) begin
            tbl_used[i] = 1'b0;
            tbl_time[i] = '0;
            tbl_price[i] = '0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty table, extremes, every request and every status but full
        dir_rows[0]  = row(REQ_REMOVE, 32'h0, 32'h0, 1'b1, ST_MISSING, 1'b1, 0, 0, 0);
        dir_rows[1]  = row(REQ_NONE, 32'h5, 32'h9, 1'b1, ST_DONE, 1'b1, 0, 0, 0);
        dir_rows[2]  = row(REQ_UPDATE, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, ST_DONE, 1'b0,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        dir_rows[3]  = row(REQ_UPDATE, 32'h8000_0000, 32'h0, 1'b1, ST_DUP, 1'b0,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        dir_rows[4]  = row(REQ_UPDATE, 32'h7FFF_FFFF, 32'h0, 1'b1, ST_DONE, 1'b0,
                           32'h0, 32'hFFFF_FFFF, 32'h0);
        dir_rows[5]  = row(REQ_CORRECT, 32'h7FFF_FFFF, 32'h1234, 1'b0, ST_DONE, 1'b0, 0, 0, 0);
        dir_rows[6]  = row(REQ_CORRECT, 32'hFFFF_FFFF, 32'h5, 1'b0, ST_DONE, 1'b0, 0, 0, 0);
        dir_rows[7]  = row(REQ_UPDATE, 32'h0, 32'hAAAA_5555, 1'b0, ST_DONE, 1'b0, 0, 0, 0);
        dir_rows[8]  = row(REQ_NONE, 32'h0, 32'h0, 1'b0, ST_DONE, 1'b0, 0, 0, 0);
        dir_rows[9]  = row(REQ_REMOVE, 32'h7FFF_FFFF, 32'h0, 1'b0, ST_DONE, 1'b0, 0, 0, 0);
        dir_rows[10] = row(REQ_REMOVE, 32'h7FFF_FFFF, 32'h0, 1'b0, ST_DONE, 1'b0, 0, 0, 0);
        dir_rows[11] = row(REQ_REMOVE, 32'h8000_0000, 32'h0, 1'b0, ST_DONE, 1'b0, 0, 0, 0);
        dir_rows[12] = row(REQ_REMOVE, 32'hFFFF_FFFF, 32'h0, 1'b0, ST_DONE, 1'b0, 0, 0, 0);
        dir_rows[13] = row(REQ_REMOVE, 32'h0, 32'h0, 1'b1, ST_DONE, 1'b1, 0, 0, 0);
        foreach (dir_rows[i]) begin
            got = apply_request(dir_rows[i].req, dir_rows[i].key, dir_rows[i].price);
            if (dir_rows[i].chk && (got.status != dir_rows[i].status
                    || got.is_empty != dir_rows[i].is_empty || got.low_price != dir_rows[i].lo
                    || got.high_price != dir_rows[i].hi || got.last_price != dir_rows[i].last))
                report_mismatch("directed row", i, i);
        end
        for (int i = 0; i < Depth; i++) tbl_used[i] = 1'b0;
        foreach (dir_rows[i]) send_beat(dir_rows[i].req, dir_rows[i].key, dir_rows[i].price);
        wait_drained();

        // fill to full, overflow by update and correction, then empty again
        for (k = 0; k < Depth; k++) send_beat(REQ_UPDATE, k * 32'h0101_0101, $urandom());
        send_beat(REQ_UPDATE, 32'hDEAD_0001, 32'h1);
        send_beat(REQ_CORRECT, 32'hDEAD_0002, 32'h2);
        send_beat(REQ_CORRECT, 32'h0101_0101, 32'h0);
        for (k = 0; k < Depth; k++) send_beat(REQ_REMOVE, k * 32'h0101_0101, 32'h0);

        // long receiver stall while requests keep coming
        hold_cycles = 300;
        for (k = 0; k < 10; k++) send_beat(REQ_UPDATE, $urandom(), $urandom());
        wait_drained();

        for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
        send_idle_pct = 12;
        recv_idle_pct = 53;
        random_phase(300);
        send_idle_pct = 53;
        recv_idle_pct = 12;
        random_phase(300);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 16; i++) key_pool[i] = (i < 8) ? $urandom() : $urandom_range(20);
        random_phase(300);

        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        k = 0;
        while (pending_results.size() != 0 && k < 100000) begin
            @(negedge i_clk);
            k++;
        end
        repeat (20) @(negedge i_clk);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
